// ===== rtl/ttgpd_pkg.sv =====
// Package for the glyph point decoder: payload structs, phase codes, flag bits.
// No dependencies.
`timescale 1ns / 1ps
package ttgpd_pkg;

  localparam int MAX_POINTS_DEF = 32;
  localparam logic [14:0] UPEM_RESET = 15'd2048;

  typedef struct packed {
    logic              action;
    logic [7:0]        data_byte;
    logic [5:0]        point_total;
    logic signed [15:0] x_start;
  } in_item_t;

  typedef struct packed {
    logic [4:0]         point_index;
    logic               axis;
    logic signed [31:0] coord_value;
    logic               on_curve;
    logic               last;
  } out_item_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_FLAGS = 2'd1,
    PH_X     = 2'd2,
    PH_Y     = 2'd3
  } phase_t;

  localparam logic ACT_START = 1'b0;

  // flag bit positions
  localparam int FB_ON     = 0;
  localparam int FB_XSHORT = 1;
  localparam int FB_YSHORT = 2;
  localparam int FB_REPEAT = 3;
  localparam int FB_XSAME  = 4;
  localparam int FB_YSAME  = 5;

  // request to the scaling unit
  typedef struct packed {
    logic [15:0] coord;
    logic        negate;
  } scale_req_t;

endpackage

// ===== rtl/ttgpd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module ttgpd_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/ttgpd_scale.sv =====
// Iterative signed scaler: coord*65536/upem, truncated, with negation and saturation.
// Depends on ttgpd_pkg.
`timescale 1ns / 1ps
module ttgpd_scale (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  ttgpd_pkg::scale_req_t   req,
  input  logic [14:0]             upem,
  output logic                    busy,
  output logic                    done,
  output logic [31:0]             result
);
  import ttgpd_pkg::*;

  logic [31:0] rem_r, rem_nxt;      // dividend shifted out, quotient in
  logic [15:0] part_r, part_nxt;    // partial remainder
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        neg_r, neg_nxt;      // final sign of quotient
  logic        zdiv_r, zdiv_nxt;
  logic        cneg_r, cneg_nxt;
  logic        done_r, done_nxt;
  logic [31:0] res_r, res_nxt;
  logic [15:0] mag;
  logic [16:0] trial;
  logic [16:0] diff;
  logic [32:0] sq;

  assign mag   = req.coord[15] ? (16'd0 - req.coord) : req.coord;
  assign trial = {part_r, rem_r[31]};
  assign diff  = trial - {2'b00, upem};

  // one quotient bit per cycle
  always_comb begin
    rem_nxt  = rem_r;
    part_nxt = part_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    neg_nxt  = neg_r;
    zdiv_nxt = zdiv_r;
    cneg_nxt = cneg_r;
    done_nxt = 1'b0;
    res_nxt  = res_r;
    sq       = '0;
    if (start) begin
      rem_nxt  = {mag, 16'd0};
      part_nxt = '0;
      cnt_nxt  = 6'd32;
      busy_nxt = 1'b1;
      cneg_nxt = req.coord[15];
      neg_nxt  = req.coord[15] ^ req.negate;
      zdiv_nxt = (upem == 15'd0);
    end else if (busy_r) begin
      if (cnt_r != 6'd0) begin
        if (!diff[16]) begin
          part_nxt = diff[15:0];
          rem_nxt  = {rem_r[30:0], 1'b1};
        end else begin
          part_nxt = trial[15:0];
          rem_nxt  = {rem_r[30:0], 1'b0};
        end
        cnt_nxt = cnt_r - 6'd1;
      end else begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        if (zdiv_r) begin
          // zero divisor: saturate by sign of coordinate, then negate
          if (neg_nxt == cneg_r) begin
            res_nxt = cneg_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
          end else begin
            res_nxt = cneg_r ? 32'h7FFF_FFFF : 32'h8000_0001;
          end
        end else begin
          sq = neg_r ? (33'd0 - {1'b0, rem_r}) : {1'b0, rem_r};
          if (!neg_r && rem_r[31]) begin
            res_nxt = 32'h7FFF_FFFF;
          end else begin
            res_nxt = sq[31:0];
          end
        end
      end
    end
  end

  // reset control state; datapath registers are not reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    part_r <= part_nxt;
    neg_r  <= neg_nxt;
    zdiv_r <= zdiv_nxt;
    cneg_r <= cneg_nxt;
    res_r  <= res_nxt;
  end

  assign busy   = busy_r;
  assign done   = done_r;
  assign result = res_r;
endmodule

// ===== rtl/truetype_glyph_point_decoder_top.sv =====
// Top level of the glyph point decoder: byte sequencer around the flag RAM
// and the iterative scaler. Depends on ttgpd_pkg, ttgpd_ram, ttgpd_scale.
`timescale 1ns / 1ps
// Usage:
//   in_valid/in_ready carry one item: a start (action 0) with point_total and
//   x_start, or one glyph data byte (action 1). Flags are stored in a 32-entry
//   RAM; coordinate bytes read the current flag back from it.
//   out_valid/out_ready carry one coordinate result; a glyph yields one x and
//   one y result per point, the final y with last set.
//   Flow: a start or flag byte is handled in the wait state itself, the last
//   flag starting the x pass; a repeat count byte copies the held flag into
//   the following entries. A byte that completes a coordinate passes the flag
//   read, the evaluation and the one bit per cycle divider before out_valid
//   rises; the next byte is taken only after that result enters the output
//   register. Points needing no byte follow one another through the divider.
//   Reset: synchronous on rst_n low; units_per_em returns to 2048 and the
//   block goes idle. The flag RAM is not cleared.
//   Stall: a result waits in the output register while out_ready is low; the
//   sequencer goes on taking items until the next result is ready, then holds
//   and takes no further item until the register frees.
//   cfg_we writes units_per_em at once; write only while the block is idle.
module truetype_glyph_point_decoder_top #(
  parameter int MAX_POINTS = ttgpd_pkg::MAX_POINTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ttgpd_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ttgpd_pkg::out_item_t out_data,
  input  logic                 cfg_we,
  input  logic [14:0]          cfg_data
);
  import ttgpd_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam logic [5:0] MAXP = 6'(MAX_POINTS);

  typedef enum logic [5:0] {
    S_IN    = 6'b000001,  // wait for an item
    S_RD    = 6'b000010,  // flag read in flight
    S_EVAL  = 6'b000100,  // decide what the current point needs
    S_RPT   = 6'b001000,  // copy repeated flag
    S_DIV   = 6'b010000,  // divider running
    S_OUT   = 6'b100000   // result waiting
  } st_t;

  st_t         st_r, st_nxt;
  phase_t      ph_r, ph_nxt;
  logic [5:0]  cur_r, cur_nxt;
  logic [5:0]  lim_r, lim_nxt;
  logic        rpend_r, rpend_nxt;
  logic [5:0]  held_r, held_nxt;
  logic [8:0]  hb_r, hb_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [7:0]  rcnt_r, rcnt_nxt;
  logic [14:0] upem_r;
  logic        pend_r, pend_nxt;   // coordinate byte waits to be applied
  logic [7:0]  byte_r, byte_nxt;
  out_item_t   ob_r, ob_nxt;
  logic        ov_r, ov_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [5:0]    wdata, rdata;
  logic          dstart, dbusy, ddone;
  logic [31:0]   dres;
  scale_req_t    dreq;
  logic          acc_in;
  logic          is_y;
  logic [1:0]    need;
  logic          same;

  ttgpd_ram #(.WIDTH(6), .DEPTH(MAX_POINTS)) u_flags (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  ttgpd_scale u_scale (
    .clk(clk), .rst_n(rst_n), .start(dstart), .req(dreq), .upem(upem_r),
    .busy(dbusy), .done(ddone), .result(dres)
  );

  assign in_ready  = (st_r == S_IN);
  assign acc_in    = in_valid && in_ready;
  assign out_valid = ov_r;
  assign out_data  = ob_r;
  assign raddr     = cur_r[AW-1:0];
  assign is_y      = (ph_r == PH_Y);
  assign same      = is_y ? rdata[FB_YSAME] : rdata[FB_XSAME];
  assign dreq.coord  = acc_r;
  assign dreq.negate = is_y;

  always_comb begin
    if (is_y ? rdata[FB_YSHORT] : rdata[FB_XSHORT]) begin
      need = 2'd1;
    end else if (same) begin
      need = 2'd0;
    end else begin
      need = 2'd2;
    end
  end

  // sequencer
  always_comb begin
    st_nxt = st_r; ph_nxt = ph_r; cur_nxt = cur_r; lim_nxt = lim_r;
    rpend_nxt = rpend_r; held_nxt = held_r; hb_nxt = hb_r; acc_nxt = acc_r;
    rcnt_nxt = rcnt_r; pend_nxt = pend_r; byte_nxt = byte_r;
    ob_nxt = ob_r; ov_nxt = ov_r;
    we = 1'b0; waddr = cur_r[AW-1:0]; wdata = '0; dstart = 1'b0;
    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end
    case (st_r)
      S_IN: begin
        if (acc_in) begin
          if (in_data.action == ACT_START) begin
            lim_nxt   = (in_data.point_total > MAXP) ? MAXP : in_data.point_total;
            cur_nxt   = '0;
            rpend_nxt = 1'b0;
            held_nxt  = '0;
            hb_nxt    = '0;
            acc_nxt   = in_data.x_start;
            ph_nxt    = (in_data.point_total == 6'd0) ? PH_IDLE : PH_FLAGS;
          end else if (ph_r == PH_FLAGS) begin
            if (rpend_r) begin
              rcnt_nxt  = in_data.data_byte;
              rpend_nxt = 1'b0;
              st_nxt    = S_RPT;
            end else begin
              we      = (cur_r < MAXP);
              wdata   = in_data.data_byte[5:0];
              cur_nxt = cur_r + 6'd1;
              if (in_data.data_byte[FB_REPEAT]) begin
                rpend_nxt = 1'b1;
                held_nxt  = in_data.data_byte[5:0];
              end else if (cur_r + 6'd1 >= lim_r) begin
                ph_nxt  = PH_X;
                cur_nxt = '0;
                hb_nxt  = '0;
                st_nxt  = S_RD;
              end
            end
          end else if (ph_r == PH_X || ph_r == PH_Y) begin
            pend_nxt = 1'b1;
            byte_nxt = in_data.data_byte;
            st_nxt   = S_RD;
          end
        end
      end
      S_RPT: begin
        if (rcnt_r != 8'd0 && cur_r < lim_r) begin
          we       = 1'b1;
          wdata    = held_r;
          cur_nxt  = cur_r + 6'd1;
          rcnt_nxt = rcnt_r - 8'd1;
        end else if (cur_r >= lim_r) begin
          ph_nxt  = PH_X;
          cur_nxt = '0;
          hb_nxt  = '0;
          st_nxt  = S_RD;
        end else begin
          st_nxt = S_IN;
        end
      end
      S_RD: st_nxt = S_EVAL;
      S_EVAL: begin
        // apply or store a waiting byte, emit a point that needs none, or wait for a byte
        if (need == 2'd0) begin
          pend_nxt = 1'b0;
          if (!pend_r || ph_r == PH_X || ph_r == PH_Y) begin
            dstart = 1'b1;
            st_nxt = S_DIV;
          end
        end else if (!pend_r) begin
          st_nxt = S_IN;
        end else if (need == 2'd1) begin
          pend_nxt = 1'b0;
          acc_nxt  = same ? (acc_r + {8'd0, byte_r}) : (acc_r - {8'd0, byte_r});
          st_nxt   = S_DIV;
        end else if (!hb_r[8]) begin
          pend_nxt = 1'b0;
          hb_nxt   = {1'b1, byte_r};
          st_nxt   = S_IN;
        end else begin
          pend_nxt = 1'b0;
          acc_nxt  = acc_r + {hb_r[7:0], byte_r};
          st_nxt   = S_DIV;
        end
        if (need != 2'd0 && pend_r && !(need == 2'd2 && !hb_r[8])) begin
          st_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (!dbusy && !ddone && !dstart) begin
          dstart = 1'b1;
        end
        if (ddone) begin
          st_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!ov_r || out_ready) begin
          ov_nxt = 1'b1;
          ob_nxt.point_index = cur_r[4:0];
          ob_nxt.axis        = is_y;
          ob_nxt.coord_value = dres;
          ob_nxt.on_curve    = is_y ? rdata[FB_ON] : 1'b0;
          ob_nxt.last        = is_y && (cur_r + 6'd1 >= lim_r);
          hb_nxt  = '0;
          cur_nxt = cur_r + 6'd1;
          st_nxt  = S_RD;
          if (cur_r + 6'd1 >= lim_r) begin
            cur_nxt = '0;
            if (is_y) begin
              ph_nxt = PH_IDLE;
              st_nxt = S_IN;
            end else begin
              ph_nxt = PH_Y;
              acc_nxt = '0;
            end
          end
        end
      end
      default: st_nxt = S_IN;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IN;
      ph_r    <= PH_IDLE;
      cur_r   <= '0;
      lim_r   <= '0;
      rpend_r <= 1'b0;
      held_r  <= '0;
      hb_r    <= '0;
      acc_r   <= '0;
      rcnt_r  <= '0;
      pend_r  <= 1'b0;
      ov_r    <= 1'b0;
      upem_r  <= UPEM_RESET;
    end else begin
      st_r    <= st_nxt;
      ph_r    <= ph_nxt;
      cur_r   <= cur_nxt;
      lim_r   <= lim_nxt;
      rpend_r <= rpend_nxt;
      held_r  <= held_nxt;
      hb_r    <= hb_nxt;
      acc_r   <= acc_nxt;
      rcnt_r  <= rcnt_nxt;
      pend_r  <= pend_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we) begin
        upem_r <= cfg_data;
      end
    end
    byte_r <= byte_nxt;
    ob_r   <= ob_nxt;
  end

  // checks
  a_st_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(st_r))
    else $error("sequencer state not one-hot");
  a_cur_lim: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_r == PH_X || ph_r == PH_Y) |-> (cur_r < lim_r))
    else $error("point cursor beyond limit");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ready) |=> (ov_r && $stable(ob_r)))
    else $error("result changed while stalled");
endmodule
